>>> rtl/lwc_pkg.sv
// ----------------------------------------------------------------------------
// lwc_pkg
// Shared types, codes and helper function of the line window clipper.
// ----------------------------------------------------------------------------
package lwc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int MAX_COORD_WIDTH = 32;
  localparam int MAX_PASSES      = 8;
  localparam int PASS_WIDTH      = $clog2(MAX_PASSES + 1);

  // Outcode bits.
  localparam logic [3:0] CODE_LEFT  = 4'b0001;
  localparam logic [3:0] CODE_RIGHT = 4'b0010;
  localparam logic [3:0] CODE_BELOW = 4'b0100;
  localparam logic [3:0] CODE_ABOVE = 4'b1000;
  localparam logic [3:0] CODE_NONE  = 4'b0000;

  // Register indexes.
  localparam logic [1:0] REG_MIN_X = 2'd0;
  localparam logic [1:0] REG_MIN_Y = 2'd1;
  localparam logic [1:0] REG_MAX_X = 2'd2;
  localparam logic [1:0] REG_MAX_Y = 2'd3;

  localparam int WIN_MIN_X_RST = -5120;
  localparam int WIN_MIN_Y_RST = -3840;
  localparam int WIN_MAX_X_RST = 5120;
  localparam int WIN_MAX_Y_RST = 3840;

  typedef logic signed [MAX_COORD_WIDTH:0] xcoord_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_CODE,
    ST_DONE
  } eng_state_t;

  // Left and right are exclusive with left tested first; likewise below/above.
  function automatic logic [3:0] outcode(input xcoord_t x, input xcoord_t y,
                                         input xcoord_t min_x, input xcoord_t min_y,
                                         input xcoord_t max_x, input xcoord_t max_y);
    logic [3:0] c;
    c = CODE_NONE;
    if (x < min_x) c = c | CODE_LEFT;
    else if (x > max_x) c = c | CODE_RIGHT;
    if (y < min_y) c = c | CODE_BELOW;
    else if (y > max_y) c = c | CODE_ABOVE;
    return c;
  endfunction

endpackage

>>> rtl/lwc_queue.sv
// ----------------------------------------------------------------------------
// lwc_queue
// Two-entry queue between the front and the clipping engine.
// ----------------------------------------------------------------------------
module lwc_queue #(
  parameter int WIDTH = 72
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

endmodule

>>> rtl/lwc_front.sv
// ----------------------------------------------------------------------------
// lwc_front
// Input stage: registers a segment and tags both endpoints with outcodes.
// ----------------------------------------------------------------------------
module lwc_front
  import lwc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int TDATA_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [TDATA_WIDTH-1:0]        s_tdata,
  input  logic signed [COORD_WIDTH-1:0] win_min_x,
  input  logic signed [COORD_WIDTH-1:0] win_min_y,
  input  logic signed [COORD_WIDTH-1:0] win_max_x,
  input  logic signed [COORD_WIDTH-1:0] win_max_y,
  output logic                          f_valid,
  input  logic                          f_ready,
  output logic [4*COORD_WIDTH+7:0]      f_data
);

  localparam int C  = COORD_WIDTH;
  localparam int XW = MAX_COORD_WIDTH + 1;

  logic [4*C-1:0]       seg;
  logic signed [C-1:0]  sx, sy, ex, ey;
  logic [3:0]           cs, ce;

  assign s_tready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (s_tready) begin
      f_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) seg <= s_tdata[4*C-1:0];
  end

  assign sx = seg[C-1:0];
  assign sy = seg[2*C-1:C];
  assign ex = seg[3*C-1:2*C];
  assign ey = seg[4*C-1:3*C];

  assign cs = outcode(XW'(sx), XW'(sy), XW'(win_min_x), XW'(win_min_y),
                      XW'(win_max_x), XW'(win_max_y));
  assign ce = outcode(XW'(ex), XW'(ey), XW'(win_min_x), XW'(win_min_y),
                      XW'(win_max_x), XW'(win_max_y));

  assign f_data = {ce, cs, seg};

endmodule

>>> rtl/lwc_divider.sv
// ----------------------------------------------------------------------------
// lwc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lwc_divider #(
  parameter int NUM_WIDTH = 33,
  parameter int DEN_WIDTH = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] dividend,
  input  logic [DEN_WIDTH-1:0] divisor,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] quotient
);

  localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0] acc;
  logic [DEN_WIDTH-1:0] rem;
  logic [DEN_WIDTH-1:0] den;
  logic [CNT_WIDTH-1:0] cnt;
  logic                 busy;
  logic [DEN_WIDTH:0]   shifted;
  logic                 fits;

  assign shifted  = {rem, acc[NUM_WIDTH-1]};
  assign fits     = (shifted >= {1'b0, den});
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_WIDTH'(NUM_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      acc <= {acc[NUM_WIDTH-2:0], fits};
      rem <= fits ? DEN_WIDTH'(shifted - {1'b0, den}) : shifted[DEN_WIDTH-1:0];
    end
  end

endmodule

>>> rtl/lwc_engine.sv
// ----------------------------------------------------------------------------
// lwc_engine
// Clipping sequencer: passes of edge selection, multiply, divide and update.
// ----------------------------------------------------------------------------
module lwc_engine
  import lwc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int TDATA_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [4*COORD_WIDTH+7:0]      q_data,
  input  logic signed [COORD_WIDTH-1:0] win_min_x,
  input  logic signed [COORD_WIDTH-1:0] win_min_y,
  input  logic signed [COORD_WIDTH-1:0] win_max_x,
  input  logic signed [COORD_WIDTH-1:0] win_max_y,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [TDATA_WIDTH-1:0]        m_tdata,
  output logic                          m_tuser
);

  localparam int C  = COORD_WIDTH;
  localparam int E  = C + 1;
  localparam int PW = 2 * C + 1;
  localparam int SW = C + 3;
  localparam int XW = MAX_COORD_WIDTH + 1;
  localparam logic [PW-1:0]     LIM  = PW'(1) << (C + 1);
  localparam logic signed [SW-1:0] MAXV = {4'b0000, {(C-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {4'b1111, {(C-1){1'b0}}};

  eng_state_t state, state_next;

  logic signed [C-1:0]  sx, sy, ex, ey;
  logic signed [E-1:0]  w, h;
  logic [3:0]           cs, ce;
  logic [PASS_WIDTH-1:0] pass;
  logic                 vis;
  logic                 on_start, axis_x;
  logic signed [C-1:0]  edge_val, base;
  logic signed [E-1:0]  num, off, den;
  logic                 neg, skip;
  logic                 out_load;

  logic [3:0]           cur;
  logic                 zero_term;
  logic [E-1:0]         mag_num, mag_off, mag_den;
  logic [2*E-1:0]       prod_full;
  logic                 div_start, div_done;
  logic [PW-1:0]        quot;
  logic [C+1:0]         qc;
  logic signed [SW-1:0] sum;
  logic signed [C-1:0]  res;
  logic signed [C-1:0]  qsx, qsy, qex, qey;

  assign qsx = q_data[C-1:0];
  assign qsy = q_data[2*C-1:C];
  assign qex = q_data[3*C-1:2*C];
  assign qey = q_data[4*C-1:3*C];

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign zero_term = (num == '0) || (den == '0);

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if ((cs == CODE_NONE && ce == CODE_NONE) || ((cs & ce) != CODE_NONE) ||
            pass >= PASS_WIDTH'(MAX_PASSES)) state_next = ST_DONE;
        else state_next = ST_MUL;
      end
      ST_MUL: begin
        div_start  = !zero_term;
        state_next = zero_term ? ST_APPLY : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_APPLY;
      end
      ST_APPLY: state_next = ST_CODE;
      ST_CODE:  state_next = ST_CHECK;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign cur = (cs != CODE_NONE) ? cs : ce;

  assign mag_num   = num[E-1] ? E'(-num) : E'(num);
  assign mag_off   = off[E-1] ? E'(-off) : E'(off);
  assign mag_den   = den[E-1] ? E'(-den) : E'(den);
  assign prod_full = mag_num * mag_off;

  // The divider takes the product directly in the multiply cycle.
  lwc_divider #(
    .NUM_WIDTH(PW),
    .DEN_WIDTH(E)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_full[PW-1:0]),
    .divisor  (mag_den),
    .done     (div_done),
    .quotient (quot)
  );

  // Quotient is clamped before the add so the sum stays within SW bits.
  assign qc  = (quot > LIM) ? LIM[C+1:0] : quot[C+1:0];
  assign sum = neg ? (SW'(base) - $signed({1'b0, qc}))
                   : (SW'(base) + $signed({1'b0, qc}));
  always_comb begin
    if (skip) res = base;
    else if (sum > MAXV) res = MAXV[C-1:0];
    else if (sum < MINV) res = MINV[C-1:0];
    else res = sum[C-1:0];
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          sx   <= qsx;
          sy   <= qsy;
          ex   <= qex;
          ey   <= qey;
          w    <= E'(qex) - E'(qsx);
          h    <= E'(qey) - E'(qsy);
          cs   <= q_data[4*C+3:4*C];
          ce   <= q_data[4*C+7:4*C+4];
          pass <= '0;
        end
      end
      ST_CHECK: begin
        vis      <= (cs == CODE_NONE) && (ce == CODE_NONE);
        on_start <= (cs != CODE_NONE);
        if ((cur & (CODE_BELOW | CODE_ABOVE)) == CODE_NONE) begin
          axis_x   <= 1'b1;
          edge_val <= ((cur & CODE_LEFT) != CODE_NONE) ? win_min_x : win_max_x;
          off      <= E'(((cur & CODE_LEFT) != CODE_NONE) ? win_min_x : win_max_x)
                      - E'(sx);
          num      <= h;
          den      <= w;
          base     <= sy;
        end else begin
          axis_x   <= 1'b0;
          edge_val <= ((cur & CODE_BELOW) != CODE_NONE) ? win_min_y : win_max_y;
          off      <= E'(((cur & CODE_BELOW) != CODE_NONE) ? win_min_y : win_max_y)
                      - E'(sy);
          num      <= w;
          den      <= h;
          base     <= sx;
        end
      end
      ST_MUL: begin
        neg  <= (num[E-1] ^ off[E-1]) ^ den[E-1];
        skip <= zero_term;
      end
      ST_APPLY: begin
        if (on_start) begin
          sx <= axis_x ? edge_val : res;
          sy <= axis_x ? res : edge_val;
        end else begin
          ex <= axis_x ? edge_val : res;
          ey <= axis_x ? res : edge_val;
        end
      end
      ST_CODE: begin
        cs   <= outcode(XW'(sx), XW'(sy), XW'(win_min_x), XW'(win_min_y),
                        XW'(win_max_x), XW'(win_max_y));
        ce   <= outcode(XW'(ex), XW'(ey), XW'(win_min_x), XW'(win_min_y),
                        XW'(win_max_x), XW'(win_max_y));
        pass <= pass + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register: holds a finished item while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= TDATA_WIDTH'({ey, ex, sy, sx});
      m_tuser <= vis;
    end
  end

endmodule

>>> rtl/line_window_clipper_top.sv
// ----------------------------------------------------------------------------
// line_window_clipper_top
// Clips line segments against a rectangular window held in registers.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one item is a segment {end_y, end_x, start_y, start_x},
//   start_x in the lowest bits, signed fixed point with 4 fractional bits.
//   Master channel m_*: one item per segment, clipped coordinates in the same
//   layout in m_tdata, and m_tuser = 1 when the segment is visible, 0 when it
//   is rejected (coordinates then hold the partially clipped endpoints).
//   The window is written through cfg_we/cfg_index/cfg_data while idle.
// Throughput:
//   The engine works on one item at a time, in P clipping passes, where P
//   is 0 to 4 (at most 8 for an inverted window). A pass that divides runs
//   the serial divider, one quotient bit per cycle over a 2*COORD_WIDTH+1
//   bit product. Front stage and queue let up to three further items be
//   taken while the engine works.
// Reset: the window returns to its default (+-320 by +-240), all queues
//   empty. When the receiver stalls, the result is held in the output
//   register and the engine waits; the front keeps accepting until full.
// ----------------------------------------------------------------------------
module line_window_clipper_top
  import lwc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // start_x, start_y, end_x, end_y, zero fill
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // clip_start_x, clip_start_y, clip_end_x, clip_end_y, zero fill
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // visible
  output logic                          m_tuser,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);

  localparam int C   = COORD_WIDTH;
  localparam int TDW = ((4 * C + 7) / 8) * 8;
  localparam int QW  = 4 * C + 8;

  logic signed [C-1:0] win_min_x, win_min_y, win_max_x, win_max_y;
  logic                f_valid, f_ready;
  logic [QW-1:0]       f_data;
  logic                q_valid, q_ready;
  logic [QW-1:0]       q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_min_x <= C'(WIN_MIN_X_RST);
      win_min_y <= C'(WIN_MIN_Y_RST);
      win_max_x <= C'(WIN_MAX_X_RST);
      win_max_y <= C'(WIN_MAX_Y_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_X: win_min_x <= cfg_data;
        REG_MIN_Y: win_min_y <= cfg_data;
        REG_MAX_X: win_max_x <= cfg_data;
        REG_MAX_Y: win_max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  lwc_front #(
    .COORD_WIDTH (C),
    .TDATA_WIDTH (TDW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .win_min_x (win_min_x),
    .win_min_y (win_min_y),
    .win_max_x (win_max_x),
    .win_max_y (win_max_y),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_data    (f_data)
  );

  lwc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  lwc_engine #(
    .COORD_WIDTH (C),
    .TDATA_WIDTH (TDW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .win_min_x (win_min_x),
    .win_min_y (win_min_y),
    .win_max_x (win_max_x),
    .win_max_y (win_max_y),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

>>> rtl/lwc_checker.sv
// ----------------------------------------------------------------------------
// lwc_checker
// Port-level assertions for the line window clipper.
// ----------------------------------------------------------------------------
module lwc_checker
  import lwc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic                          m_tuser,
  input logic                          cfg_we,
  input logic [1:0]                    cfg_index,
  input logic [COORD_WIDTH-1:0]        cfg_data
);

  localparam int C = COORD_WIDTH;

  logic signed [C-1:0] min_x, min_y, max_x, max_y;
  logic signed [C-1:0] osx, osy, oex, oey;
  logic [2:0]          pending;
  logic                in_acc, out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;
  assign osx = m_tdata[C-1:0];
  assign osy = m_tdata[2*C-1:C];
  assign oex = m_tdata[3*C-1:2*C];
  assign oey = m_tdata[4*C-1:3*C];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= C'(WIN_MIN_X_RST);
      min_y <= C'(WIN_MIN_Y_RST);
      max_x <= C'(WIN_MAX_X_RST);
      max_y <= C'(WIN_MAX_Y_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X: min_x <= cfg_data;
        REG_MIN_Y: min_y <= cfg_data;
        REG_MAX_X: max_x <= cfg_data;
        default:   max_y <= cfg_data;
      endcase
    end
  end

  // Items inside the block: front stage, two queue entries, engine, output.
  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else if (in_acc && !out_acc) pending <= pending + 3'd1;
    else if (out_acc && !in_acc) pending <= pending - 3'd1;
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (pending != 3'd0) && (pending <= 3'd5))
    else $error("result without a pending item");

  a_visible_inside: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> osx >= min_x && osx <= max_x && osy >= min_y &&
      osy <= max_y && oex >= min_x && oex <= max_x && oey >= min_y && oey <= max_y)
    else $error("visible segment lies outside the window");

endmodule

bind line_window_clipper_top lwc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lwc_checker (.*);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the line window clipper: segments are driven on the slave
// stream, clipped segments are predicted in the bench and compared in order
// with what the master stream delivers, over several window settings and
// several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import lwc_pkg::*;

  localparam int CW = 16;
  localparam int DW = ((4 * CW + 7) / 8) * 8;

  typedef struct packed {
    logic [CW-1:0] ey;
    logic [CW-1:0] ex;
    logic [CW-1:0] sy;
    logic [CW-1:0] sx;
  } seg_t;

  typedef struct {
    seg_t coords;
    logic vis;
  } clip_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MIN_X;
  logic [CW-1:0] cfg_data = '0;
  logic in_taken = 1'b0;

  line_window_clipper_top #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Window as the bench believes it to be.
  longint wmin_x, wmin_y, wmax_x, wmax_y;

  seg_t  pending_segs[$];
  clip_t expected_clips[$];
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_off = 0;
  int    sent = 0;

  function automatic longint sx16(logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [3:0] region(longint x, longint y);
    logic [3:0] c;
    c = CODE_NONE;
    if (x < wmin_x) c |= CODE_LEFT;
    else if (x > wmax_x) c |= CODE_RIGHT;
    if (y < wmin_y) c |= CODE_BELOW;
    else if (y > wmax_y) c |= CODE_ABOVE;
    return c;
  endfunction

  // base + trunc(num * off / den), saturated, with base kept on a zero term.
  function automatic longint slide(longint base, longint num, longint off, longint den);
    longint q, r, lim;
    bit neg;
    if (num == 0 || den == 0 || off == 0) return base;
    q = ((num < 0 ? -num : num) * (off < 0 ? -off : off)) / (den < 0 ? -den : den);
    lim = longint'(1) << (CW + 1);
    if (q > lim) q = lim;
    neg = ((num < 0) != (off < 0)) != (den < 0);
    r = neg ? base - q : base + q;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic clip_t clip_segment(seg_t s);
    longint x0, y0, x1, y1, w, h, nx, ny;
    logic [3:0] c0, c1, cur;
    bit on_start;
    clip_t r;
    x0 = sx16(s.sx); y0 = sx16(s.sy); x1 = sx16(s.ex); y1 = sx16(s.ey);
    w = x1 - x0; h = y1 - y0;
    c0 = region(x0, y0); c1 = region(x1, y1);
    r.vis = 1'b0;
    for (int pass = 0; ; pass++) begin
      if (c0 == CODE_NONE && c1 == CODE_NONE) begin
        r.vis = 1'b1;
        break;
      end
      if ((c0 & c1) != CODE_NONE) break;
      if (pass >= MAX_PASSES) break;
      on_start = (c0 != CODE_NONE);
      cur = on_start ? c0 : c1;
      if ((cur & (CODE_BELOW | CODE_ABOVE)) == CODE_NONE) begin
        nx = (cur & CODE_LEFT) ? wmin_x : wmax_x;
        ny = slide(y0, h, nx - x0, w);
      end else begin
        ny = (cur & CODE_BELOW) ? wmin_y : wmax_y;
        nx = slide(x0, w, ny - y0, h);
      end
      if (on_start) begin
        x0 = nx; y0 = ny; c0 = region(x0, y0);
      end else begin
        x1 = nx; y1 = ny; c1 = region(x1, y1);
      end
    end
    r.coords.sx = x0[CW-1:0]; r.coords.sy = y0[CW-1:0];
    r.coords.ex = x1[CW-1:0]; r.coords.ey = y1[CW-1:0];
    return r;
  endfunction

  // The handshake is judged at the rising edge where it happens.
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
  end

  // Driver: offers the head of the queue; the prediction is made on acceptance.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        expected_clips.push_back(clip_segment(seg_t'(s_tdata[4*CW-1:0])));
        void'(pending_segs.pop_front());
        sent++;
      end
      if (s_tvalid && !in_taken) begin
        // Hold the offered item until it is taken.
      end else if (pending_segs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata <= DW'(pending_segs[0]);
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    clip_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_clips.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h vis %b", m_tdata, m_tuser);
      end else begin
        e = expected_clips.pop_front();
        if (m_tdata[4*CW-1:0] !== e.coords || m_tuser !== e.vis) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h vis %b, got %h vis %b",
                     e.coords, e.vis, m_tdata[4*CW-1:0], m_tuser);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, longint val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_X: wmin_x = sx16(val[CW-1:0]);
      REG_MIN_Y: wmin_y = sx16(val[CW-1:0]);
      REG_MAX_X: wmax_x = sx16(val[CW-1:0]);
      default:   wmax_y = sx16(val[CW-1:0]);
    endcase
  endtask

  task automatic set_window(longint x0, longint y0, longint x1, longint y1);
    write_reg(REG_MIN_X, x0);
    write_reg(REG_MIN_Y, y0);
    write_reg(REG_MAX_X, x1);
    write_reg(REG_MAX_Y, y1);
  endtask

  // Waits until every offered item has produced its result, then lets the
  // engine settle, so a register write can never meet a busy block.
  task automatic drain;
    while (pending_segs.size() > 0 || s_tvalid || expected_clips.size() > 0)
      @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return CW'($urandom());
      1: return CW'($signed(($urandom_range(14000)) - 7000));
      2: return CW'($signed(($urandom_range(1000)) - 500));
      default: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  task automatic add_seg(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c,
                         logic [CW-1:0] d);
    seg_t s;
    s.sx = a; s.sy = b; s.ex = c; s.ey = d;
    pending_segs.push_back(s);
  endtask

  task automatic random_phase(int n);
    int m;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(9);
      // Mostly segments near the window, so several passes are taken.
      m = (m < 2) ? 0 : (m < 8) ? 1 : (m < 9) ? 2 : 3;
      add_seg(rand_coord(m), rand_coord(m), rand_coord(m), rand_coord(m));
    end
    drain();
  endtask

  initial begin
    wmin_x = WIN_MIN_X_RST; wmin_y = WIN_MIN_Y_RST;
    wmax_x = WIN_MAX_X_RST; wmax_y = WIN_MAX_Y_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed segments on the reset window.
    add_seg(16'd0, 16'd0, 16'd100, 16'd100);                 // fully inside
    add_seg(-16'sd8000, 16'd0, 16'd8000, 16'd0);             // horizontal crossing
    add_seg(16'd0, -16'sd6000, 16'd0, 16'd6000);             // vertical crossing
    add_seg(-16'sd8000, -16'sd6000, 16'd8000, 16'd6000);     // diagonal, two passes
    add_seg(-16'sd8000, 16'd5000, -16'sd7000, 16'd6000);     // shared code, rejected
    add_seg(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);         // extremes
    add_seg(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    add_seg(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);         // zero length outside
    add_seg(-16'sd6000, 16'd3000, 16'd0, 16'd7000);          // both ends clipped, visible
    add_seg(16'd5120, 16'd3840, -16'sd5120, -16'sd3840);     // on the corners
    add_seg(16'd9000, 16'd0, 16'd0, 16'd0);                  // end inside, start moves
    add_seg(16'd0, 16'd0, 16'd0, 16'd9000);                  // end point moves
    drain();

    // Inverted window reaches the pass limit.
    set_window(1000, 1000, -1000, -1000);
    add_seg(16'd0, 16'd0, 16'd50, 16'd30);
    add_seg(-16'sd3000, 16'd2000, 16'd3000, -16'sd2000);
    random_phase(40);

    // Extreme window, saturation of computed coordinates.
    set_window(-32768, -32768, 32767, 32767);
    random_phase(50);
    set_window(-32767, 32766, -32766, 32767);
    add_seg(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    random_phase(50);

    set_window(-4000, -3000, 6000, 2000);
    random_phase(400);
    send_idle_pct = 80;
    random_phase(300);
    send_idle_pct = 0; recv_stall_pct = 80;
    random_phase(300);
    send_idle_pct = 20; recv_stall_pct = 20;
    set_window(-5120, -3840, 5120, 3840);
    random_phase(300);

    // Long receiver hold-off while the sender keeps offering.
    send_idle_pct = 0; recv_stall_pct = 0;
    @(negedge clk);
    hold_off <= 3000;
    random_phase(100);

    repeat (200) @(negedge clk);
    if (mismatches == 0 && expected_clips.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
